### hw/rtl/ncp_pkg.sv
package ncp_pkg;

   // Operand and result widths
   localparam int unsigned CompWidth  = 16;
   localparam int unsigned ProdWidth  = 2 * CompWidth;
   localparam int unsigned MagWidth   = 2 * CompWidth;
   localparam int unsigned SumWidth   = 2 * MagWidth;
   localparam int unsigned RootWidth  = MagWidth;
   localparam int unsigned QuotWidth  = 15;
   localparam int unsigned NumLanes   = 3;

   // Unit length in Q1.14
   localparam logic [QuotWidth-1:0] QOne = 15'd16384;

   // One cross product component as sign and magnitude
   typedef struct packed {
      logic                neg;
      logic [MagWidth-1:0] mag;
   } comp_type;

   // Digit-by-digit square root working set
   typedef struct packed {
      logic [SumWidth-1:0]  rad;
      logic [RootWidth:0]   rem;
      logic [RootWidth-1:0] root;
   } sqrt_type;

endpackage

### hw/rtl/normalized_cross_product_core.sv
// Unit normal of two Q1.14 vectors. One transaction enters per clock and its result passes
// through one register stage each for the six products, the cross product, the squares and
// the sum of squares, 32 stages of the square root (one root bit each), 15 stages of the
// three parallel dividers (one quotient bit each) and the output register.
// When the output register holds a result that is stalled, the whole pipeline holds and
// req_stall is raised; otherwise a new transaction is taken every cycle. A zero-length
// cross product gives zero components with degenerate set.
module normalized_cross_product_core
   import ncp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [CompWidth-1:0] req_first_x,
   input  logic signed [CompWidth-1:0] req_first_y,
   input  logic signed [CompWidth-1:0] req_first_z,
   input  logic signed [CompWidth-1:0] req_second_x,
   input  logic signed [CompWidth-1:0] req_second_y,
   input  logic signed [CompWidth-1:0] req_second_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [CompWidth-1:0] rsp_normal_x,
   output logic signed [CompWidth-1:0] rsp_normal_y,
   output logic signed [CompWidth-1:0] rsp_normal_z,
   output logic                        rsp_degenerate
);

   localparam int unsigned SqrtStages = RootWidth;
   localparam int unsigned DivStages  = QuotWidth;

   logic advance;

   // stage 1: products
   logic signed [ProdWidth-1:0] prod_ff [6];
   logic                        p1_v_ff;
   // stage 2: cross product
   comp_type                    cr_ff [NumLanes];
   logic                        p2_v_ff;
   // stage 3: squares
   logic [SumWidth-1:0]         sq_ff [NumLanes];
   comp_type                    p3_c_ff [NumLanes];
   logic                        p3_v_ff;
   // stage 4: sum of squares
   logic [SumWidth-1:0]         sum_ff;
   comp_type                    p4_c_ff [NumLanes];
   logic                        p4_v_ff;
   // square root stages
   sqrt_type                    rt_ff [SqrtStages];
   comp_type                    rt_c_ff [SqrtStages][NumLanes];
   logic                        rt_v_ff [SqrtStages];
   // divider stages
   logic [MagWidth-1:0]         dv_rem_ff [DivStages][NumLanes];
   logic [QuotWidth-1:0]        dv_q_ff [DivStages][NumLanes];
   logic                        dv_neg_ff [DivStages][NumLanes];
   logic [RootWidth-1:0]        dv_len_ff [DivStages];
   logic                        dv_v_ff [DivStages];
   // output register
   logic signed [CompWidth-1:0] out_ff [NumLanes];
   logic                        out_deg_ff;
   logic                        out_v_ff;

   // hold everything while a finished result is stalled
   assign advance   = !out_v_ff || !rsp_stall;
   assign req_stall = !advance;

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (advance) begin
         p1_v_ff <= req_valid;
      end
      if (advance) begin
         prod_ff[0] <= req_first_y * req_second_z;
         prod_ff[1] <= req_first_z * req_second_y;
         prod_ff[2] <= req_first_z * req_second_x;
         prod_ff[3] <= req_first_x * req_second_z;
         prod_ff[4] <= req_first_x * req_second_y;
         prod_ff[5] <= req_first_y * req_second_x;
      end
   end

   // cross product as sign and magnitude
   for (genvar gl = 0; gl < NumLanes; gl++) begin : g_cross
      logic signed [ProdWidth:0] diff;
      logic [ProdWidth:0]        absv;
      always_comb begin
         diff = {prod_ff[2*gl][ProdWidth-1], prod_ff[2*gl]}
              - {prod_ff[2*gl+1][ProdWidth-1], prod_ff[2*gl+1]};
         absv = diff[ProdWidth] ? (~diff + 1'b1) : diff;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            cr_ff[gl].neg <= diff[ProdWidth];
            cr_ff[gl].mag <= absv[MagWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else if (advance) begin
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
      end
   end

   // squares, then their sum (wraps at the sum width)
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < NumLanes; l++) begin
            sq_ff[l]   <= SumWidth'(cr_ff[l].mag) * SumWidth'(cr_ff[l].mag);
            p3_c_ff[l] <= cr_ff[l];
            p4_c_ff[l] <= p3_c_ff[l];
         end
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   // square root, one root bit per stage
   for (genvar gs = 0; gs < SqrtStages; gs++) begin : g_sqrt
      localparam int unsigned Prv = (gs == 0) ? 0 : gs - 1;
      sqrt_type                prev;
      logic [RootWidth+2:0]    trial_rem;
      logic [RootWidth+1:0]    trial;
      logic                    ge;
      sqrt_type                rt_in;
      always_comb begin
         if (gs == 0) begin
            prev.rad  = sum_ff;
            prev.rem  = '0;
            prev.root = '0;
         end else begin
            prev = rt_ff[Prv];
         end
         trial_rem = {prev.rem, prev.rad[SumWidth-1 -: 2]};
         trial     = {prev.root, 2'b01};
         ge        = trial_rem >= {1'b0, trial};
         rt_in.rad  = {prev.rad[SumWidth-3:0], 2'b00};
         rt_in.rem  = ge ? (RootWidth+1)'(trial_rem - {1'b0, trial})
                         : trial_rem[RootWidth:0];
         rt_in.root = {prev.root[RootWidth-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_v_ff[gs] <= 1'b0;
         end else if (advance) begin
            rt_v_ff[gs] <= (gs == 0) ? p4_v_ff : rt_v_ff[Prv];
         end
         if (advance) begin
            rt_ff[gs] <= rt_in;
            for (int l = 0; l < NumLanes; l++) begin
               rt_c_ff[gs][l] <= (gs == 0) ? p4_c_ff[l] : rt_c_ff[Prv][l];
            end
         end
      end
   end

   // restoring division of magnitude * 2^14 by the length, one quotient bit per stage
   for (genvar gd = 0; gd < DivStages; gd++) begin : g_div
      localparam int unsigned Prv = (gd == 0) ? 0 : gd - 1;
      logic [RootWidth-1:0] len;
      always_comb begin
         len = (gd == 0) ? rt_ff[SqrtStages-1].root : dv_len_ff[Prv];
      end
      for (genvar gl = 0; gl < NumLanes; gl++) begin : g_lane
         logic [MagWidth:0]    rin;
         logic                 ge;
         logic [MagWidth-1:0]  rem_in;
         logic [QuotWidth-1:0] q_in;
         always_comb begin
            if (gd == 0) begin
               rin  = {1'b0, rt_c_ff[SqrtStages-1][gl].mag};
               ge   = rin >= {1'b0, len};
               q_in = {{(QuotWidth-1){1'b0}}, ge};
            end else begin
               rin  = {dv_rem_ff[Prv][gl], 1'b0};
               ge   = rin >= {1'b0, len};
               q_in = {dv_q_ff[Prv][gl][QuotWidth-2:0], ge};
            end
            rem_in = ge ? MagWidth'(rin - {1'b0, len}) : rin[MagWidth-1:0];
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               dv_rem_ff[gd][gl] <= rem_in;
               dv_q_ff[gd][gl]   <= q_in;
               dv_neg_ff[gd][gl] <= (gd == 0) ? rt_c_ff[SqrtStages-1][gl].neg
                                              : dv_neg_ff[Prv][gl];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[gd] <= 1'b0;
         end else if (advance) begin
            dv_v_ff[gd] <= (gd == 0) ? rt_v_ff[SqrtStages-1] : dv_v_ff[Prv];
         end
         if (advance) begin
            dv_len_ff[gd] <= len;
         end
      end
   end

   // clamp, apply sign, flag a zero length
   for (genvar gl = 0; gl < NumLanes; gl++) begin : g_out
      logic [QuotWidth-1:0]        q_sat;
      logic signed [CompWidth-1:0] val_in;
      always_comb begin
         q_sat = (dv_q_ff[DivStages-1][gl] > QOne) ? QOne : dv_q_ff[DivStages-1][gl];
         if (dv_len_ff[DivStages-1] == '0) begin
            val_in = '0;
         end else if (dv_neg_ff[DivStages-1][gl]) begin
            val_in = -$signed({1'b0, q_sat});
         end else begin
            val_in = $signed({1'b0, q_sat});
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            out_ff[gl] <= val_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= dv_v_ff[DivStages-1];
      end
      if (advance) begin
         out_deg_ff <= dv_len_ff[DivStages-1] == '0;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_normal_x   = out_ff[0];
   assign rsp_normal_y   = out_ff[1];
   assign rsp_normal_z   = out_ff[2];
   assign rsp_degenerate = out_deg_ff;

`ifndef SYNTHESIS
   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with non-zero components");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= 16384 && rsp_normal_x >= -16384
                 && rsp_normal_y <= 16384 && rsp_normal_y >= -16384
                 && rsp_normal_z <= 16384 && rsp_normal_z >= -16384)
      else $error("normal component outside unit range");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(p1_v_ff) && $stable(out_v_ff))
      else $error("pipeline moved while held");
`endif

endmodule

### test/tb_normalized_cross_product_core.sv
`timescale 1ns / 100ps

module tb_normalized_cross_product_core;

   localparam int Latency    = 52;
   localparam int IdleLimit  = 20000;
   localparam logic signed [15:0] QUnit = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degen;
   } normal_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [15:0] req_first_x, req_first_y, req_first_z;
   logic signed [15:0] req_second_x, req_second_y, req_second_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   normal_type expected_normals[$];
   int      error_count = 0;
   int      idle_cycles;
   bit      stall_heavy;

   normalized_cross_product_core u_top (.*);

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Integer square root, floor, bit by bit
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = v;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Scale one component to Q1.14 by the length, truncating and clamping
   function automatic logic signed [15:0] unit_comp(input longint c, input logic [63:0] len);
      logic [63:0] m;
      logic [63:0] q;
      m = (c < 0) ? 64'(-c) : 64'(c);
      q = (m * 64'd16384) / len;
      if (q > 64'd16384) q = 64'd16384;
      return (c < 0) ? -16'(q) : 16'(q);
   endfunction

   function automatic normal_type predict_normal(input logic signed [15:0] ax, ay, az,
                                                 input logic signed [15:0] bx, by, bz);
      longint cx, cy, cz;
      logic [63:0] sum_sq;
      logic [63:0] len;
      normal_type n;
      cx = longint'(ay) * bz - longint'(az) * by;
      cy = longint'(az) * bx - longint'(ax) * bz;
      cz = longint'(ax) * by - longint'(ay) * bx;
      sum_sq = 64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz);
      len = floor_sqrt(sum_sq);
      if (len == 0) begin
         n = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd0, degen: 1'b1};
      end else begin
         n.nx = unit_comp(cx, len);
         n.ny = unit_comp(cy, len);
         n.nz = unit_comp(cz, len);
         n.degen = 1'b0;
      end
      return n;
   endfunction

   // Drive one transaction and hold it until taken
   task automatic send_pair(input logic signed [15:0] ax, ay, az, bx, by, bz);
      req_valid    <= 1'b1;
      req_first_x  <= ax;
      req_first_y  <= ay;
      req_first_z  <= az;
      req_second_x <= bx;
      req_second_y <= by;
      req_second_z <= bz;
      do @(posedge clock); while (req_stall);
      expected_normals.push_back(predict_normal(ax, ay, az, bx, by, bz));
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return 16'(signed'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // Extremes, zero length and parallel vectors
   task automatic test_directed();
      logic signed [15:0] mn, mx, z0;
      mn = 16'sh8000;
      mx = 16'sh7FFF;
      z0 = 16'sd0;
      send_pair(z0, z0, z0, z0, z0, z0);
      send_pair(QUnit, z0, z0, z0, QUnit, z0);
      send_pair(z0, QUnit, z0, QUnit, z0, z0);
      send_pair(z0, z0, QUnit, QUnit, z0, z0);
      send_pair(mn, mn, mn, mn, mn, mn);
      send_pair(mx, mx, mx, mx, mx, mx);
      send_pair(mn, z0, z0, z0, mn, z0);
      send_pair(mn, z0, z0, z0, mx, z0);
      send_pair(mx, mn, mx, mn, mx, mn);
      send_pair(mn, mx, z0, mx, mn, mx);
      send_pair(16'sd100, 16'sd200, 16'sd300, 16'sd200, 16'sd400, 16'sd600);
      send_pair(16'sd1, z0, z0, z0, 16'sd1, z0);
      send_pair(-16'sd1, z0, z0, z0, 16'sd1, z0);
      send_pair(16'sd1, 16'sd1, z0, 16'sd1, -16'sd1, z0);
      send_pair(mx, 16'sd1, -16'sd1, 16'sd1, mn, mx);
      send_pair(-16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1);
      send_pair(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
      send_pair(16'sd3, 16'sd4, z0, z0, z0, 16'sd1);
      pause_sender(1);
   endtask

   // Hold the sender until the pipeline has drained
   task automatic test_drain_pause();
      send_pair(16'sd7, -16'sd3, 16'sd11, 16'sd2, 16'sd5, -16'sd9);
      req_valid <= 1'b0;
      while (expected_normals.size() != 0) @(negedge clock);
      send_pair(-16'sd7, 16'sd3, -16'sd11, 16'sd2, 16'sd5, -16'sd9);
   endtask

   // Random bursts, with parallel pairs mixed in
   task automatic test_random(input int count);
      int left;
      int burst;
      logic signed [15:0] ax, ay, az, bx, by, bz;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && left > 0; i++) begin
            ax = rand_comp(); ay = rand_comp(); az = rand_comp();
            if ($urandom_range(0, 9) == 0) begin
               bx = ax; by = ay; bz = az;
            end else begin
               bx = rand_comp(); by = rand_comp(); bz = rand_comp();
            end
            send_pair(ax, ay, az, bx, by, bz);
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
         if (left == count / 2) stall_heavy = ~stall_heavy;
      end
      req_valid <= 1'b0;
   endtask

   // Receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_heavy) begin
         rsp_stall <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_stall <= ($urandom_range(0, 4) == 0);
      end
   end

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            want = expected_normals.pop_front();
            if (rsp_normal_x !== want.nx) begin
               $error("normal_x: expected %0d, got %0d", want.nx, rsp_normal_x);
               error_count++;
            end
            if (rsp_normal_y !== want.ny) begin
               $error("normal_y: expected %0d, got %0d", want.ny, rsp_normal_y);
               error_count++;
            end
            if (rsp_normal_z !== want.nz) begin
               $error("normal_z: expected %0d, got %0d", want.nz, rsp_normal_z);
               error_count++;
            end
            if (rsp_degenerate !== want.degen) begin
               $error("degenerate: expected %0b, got %0b", want.degen, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stall_heavy  = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_first_x  = '0;
      req_first_y  = '0;
      req_first_z  = '0;
      req_second_x = '0;
      req_second_y = '0;
      req_second_z = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_drain_pause();
      test_random(800);

      while (expected_normals.size() != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
      if (error_count == 0 && expected_normals.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
